### sv/e2cal_pkg.sv
// Shared constants, types and helper functions of the epoch to calendar converter.
`timescale 1ns / 1ps

package e2cal_pkg;

    localparam int EPOCH_BITS_DEF  = 33;
    localparam int ZONE_BITS       = 17;
    localparam int SECS_PER_DAY    = 86400;
    localparam int SECS_PER_HOUR   = 3600;
    localparam int SECS_PER_MIN    = 60;
    localparam int BASE_YEAR       = 1970;
    localparam int DAYS_YEAR       = 365;
    localparam int DAYS_LEAP_YEAR  = 366;
    localparam int LEAP_CYCLE      = 4;
    localparam int CENTURY         = 100;
    localparam int QUAD_CENTURY    = 400;
    localparam int FEB_DAYS        = 28;
    localparam int FEB_LEAP_DAYS   = 29;
    localparam int HOUR_STEPS      = 5;
    localparam int MIN_STEPS       = 6;
    localparam int DAYS_PER_WEEK   = 7;
    localparam int WEEKDAY_BASE    = 4;

    localparam logic [3:0] MON_JAN = 4'd0;
    localparam logic [3:0] MON_FEB = 4'd1;
    localparam logic [3:0] MON_APR = 4'd3;
    localparam logic [3:0] MON_JUN = 4'd5;
    localparam logic [3:0] MON_SEP = 4'd8;
    localparam logic [3:0] MON_NOV = 4'd10;
    localparam logic [3:0] MON_DEC = 4'd11;

    typedef struct packed {
        logic load;
        logic step;
    } t_year_ctl;

    typedef struct packed {
        logic [11:0] year;
        logic        leap;
    } t_year_info;

    function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        case (month) inside
            MON_APR, MON_JUN, MON_SEP, MON_NOV: len = 5'd30;
            MON_FEB: len = leap ? 5'(FEB_LEAP_DAYS) : 5'(FEB_DAYS);
            default: len = 5'd31;
        endcase
        return len;
    endfunction

    function automatic logic [2:0] wday_add(input logic [2:0] wday, input logic [1:0] inc);
        logic [3:0] sum;
        sum = 4'(wday) + 4'(inc);
        if (sum >= 4'(DAYS_PER_WEEK)) begin
            sum = sum - 4'(DAYS_PER_WEEK);
        end
        return sum[2:0];
    endfunction

    function automatic logic [2:0] wday_mod(input logic [5:0] value);
        logic [5:0] v;
        v = value;
        for (int i = 0; i < 5; i++) begin
            if (v >= 6'(DAYS_PER_WEEK)) begin
                v = v - 6'(DAYS_PER_WEEK);
            end
        end
        return v[2:0];
    endfunction

endpackage

### sv/e2cal_in_if.sv
// Input channel carrying one epoch second count per item.
`timescale 1ns / 1ps

interface e2cal_in_if #(
    parameter int EPOCH_BITS = e2cal_pkg::EPOCH_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic [EPOCH_BITS-1:0] epoch_seconds;

    modport source (output valid, output epoch_seconds, input ready);
    modport sink   (input valid, input epoch_seconds, output ready);
endinterface

### sv/e2cal_out_if.sv
// Output channel carrying one calendar date and time of day per item.
`timescale 1ns / 1ps

interface e2cal_out_if;
    logic        valid;
    logic        ready;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day_of_month;
    logic [8:0]  day_of_year;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [2:0]  weekday;
    logic        range_error;

    modport source (
        output valid, output year, output month, output day_of_month,
        output day_of_year, output hour, output minute, output second,
        output weekday, output range_error, input ready
    );
    modport sink (
        input valid, input year, input month, input day_of_month,
        input day_of_year, input hour, input minute, input second,
        input weekday, input range_error, output ready
    );
endinterface

### sv/e2cal_cfg_if.sv
// Configuration write channel for the time zone offset register.
`timescale 1ns / 1ps

interface e2cal_cfg_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [e2cal_pkg::ZONE_BITS-1:0] zone_offset_seconds;

    modport source (output valid, output zone_offset_seconds, input ready);
    modport sink   (input valid, input zone_offset_seconds, output ready);
endinterface

### sv/epoch_seconds_to_calendar.sv
// Top level of the epoch second to Gregorian calendar converter.
// One item first splits days from the second of day by shifted subtraction, then finds
// hour and minute the same way, then steps once per whole year past 1970 and once per
// whole month, every step going through the single shared subtract and compare unit.
// An item whose zone-adjusted count is negative or too large returns its error result
// in the cycle after acceptance. Input is refused from acceptance until the result has
// been taken. The zone offset register resets to zero; the user must write it only while
// the block is idle, as the block itself does not enforce this.
`timescale 1ns / 1ps

module epoch_seconds_to_calendar #(
    parameter int EPOCH_BITS = e2cal_pkg::EPOCH_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    e2cal_in_if.sink    i_epoch,
    e2cal_cfg_if.sink   i_cfg,
    e2cal_out_if.source o_cal
);

    logic signed [e2cal_pkg::ZONE_BITS-1:0] r_zone;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zone <= '0;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_zone <= i_cfg.zone_offset_seconds;
        end
    end

    e2cal_core #(.EPOCH_BITS(EPOCH_BITS)) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_zone  (r_zone),
        .i_epoch (i_epoch),
        .o_cal   (o_cal)
    );

endmodule

### sv/e2cal_sub.sv
// Shared subtract and compare unit used by every step of the sequencer.
`timescale 1ns / 1ps

module e2cal_sub #(
    parameter int W = e2cal_pkg::EPOCH_BITS_DEF + 1
) (
    input  logic [W-1:0] i_a,
    input  logic [W-1:0] i_b,
    output logic [W-1:0] o_diff,
    output logic         o_ge
);

    logic [W:0] full;

    assign full   = {1'b0, i_a} - {1'b0, i_b};
    assign o_diff = full[W-1:0];
    assign o_ge   = ~full[W];

endmodule

### sv/e2cal_yrctr.sv
// Year counter with modulo 4, 100 and 400 tracking for the Gregorian leap rule.
`timescale 1ns / 1ps

module e2cal_yrctr (
    input  logic                  i_clk,
    input  e2cal_pkg::t_year_ctl  i_ctl,
    output e2cal_pkg::t_year_info o_info
);

    logic [11:0] r_year;
    logic [1:0]  r_m4;
    logic [6:0]  r_m100;
    logic [8:0]  r_m400;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_year <= 12'(e2cal_pkg::BASE_YEAR);
            r_m4   <= 2'(e2cal_pkg::BASE_YEAR % e2cal_pkg::LEAP_CYCLE);
            r_m100 <= 7'(e2cal_pkg::BASE_YEAR % e2cal_pkg::CENTURY);
            r_m400 <= 9'(e2cal_pkg::BASE_YEAR % e2cal_pkg::QUAD_CENTURY);
        end else if (i_ctl.step) begin
            r_year <= r_year + 12'd1;
            r_m4   <= r_m4 + 2'd1;
            r_m100 <= (r_m100 == 7'(e2cal_pkg::CENTURY - 1)) ? '0 : r_m100 + 7'd1;
            r_m400 <= (r_m400 == 9'(e2cal_pkg::QUAD_CENTURY - 1)) ? '0 : r_m400 + 9'd1;
        end
    end

    assign o_info.year = r_year;
    assign o_info.leap = (r_m4 == '0) && ((r_m100 != '0) || (r_m400 == '0));

endmodule

### sv/e2cal_core.sv
// Sequencer that divides, peels off years and months, and holds the result.
`timescale 1ns / 1ps

module e2cal_core #(
    parameter int EPOCH_BITS = e2cal_pkg::EPOCH_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic signed [e2cal_pkg::ZONE_BITS-1:0] i_zone,
    e2cal_in_if.sink                               i_epoch,
    e2cal_out_if.source                            o_cal
);

    localparam int AW   = EPOCH_BITS + 1;
    localparam int DQ   = EPOCH_BITS - 16;
    localparam int CNTW = $clog2(DQ);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DAYS,
        S_HOUR,
        S_MIN,
        S_YEAR,
        S_MONTH,
        S_DONE
    } t_state;

    t_state                  r_state;
    logic [AW-1:0]           r_acc;
    logic [AW-1:0]           r_dvs;
    logic [DQ-1:0]           r_days;
    logic [CNTW-1:0]         r_cnt;
    logic [4:0]              r_hour;
    logic [5:0]              r_min;
    logic [5:0]              r_sec;
    logic [3:0]              r_month;
    logic [8:0]              r_yday;
    logic [4:0]              r_dom;
    logic [2:0]              r_wday;
    logic                    r_err;

    logic signed [EPOCH_BITS+1:0] adj;
    logic                         adj_bad;
    logic                         in_acc;
    logic [AW-1:0]                sub_b;
    logic [AW-1:0]                diff;
    logic                         ge;
    logic [4:0]                   mlen;
    logic                         cnt_end;
    e2cal_pkg::t_year_ctl         yctl;
    e2cal_pkg::t_year_info        yinfo;

    assign adj     = $signed({2'b00, i_epoch.epoch_seconds}) + (EPOCH_BITS + 2)'(i_zone);
    assign adj_bad = adj[EPOCH_BITS+1] | adj[EPOCH_BITS];
    assign in_acc  = i_epoch.valid & i_epoch.ready;
    assign mlen    = e2cal_pkg::month_len(r_month, yinfo.leap);
    assign cnt_end = (r_cnt == '0);

    always_comb begin
        unique case (r_state)
            S_YEAR:  sub_b = yinfo.leap ? AW'(e2cal_pkg::DAYS_LEAP_YEAR)
                                        : AW'(e2cal_pkg::DAYS_YEAR);
            S_MONTH: sub_b = AW'(mlen);
            default: sub_b = r_dvs;
        endcase
    end

    e2cal_sub #(.W(AW)) u_sub (
        .i_a    (r_acc),
        .i_b    (sub_b),
        .o_diff (diff),
        .o_ge   (ge)
    );

    always_comb begin
        yctl.load = (r_state == S_MIN) && cnt_end;
        yctl.step = (r_state == S_YEAR) && ge;
    end

    e2cal_yrctr u_yrctr (
        .i_clk  (i_clk),
        .i_ctl  (yctl),
        .o_info (yinfo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (adj_bad) begin
                            r_err   <= 1'b1;
                            r_month <= '0;
                            r_dom   <= '0;
                            r_yday  <= '0;
                            r_hour  <= '0;
                            r_min   <= '0;
                            r_sec   <= '0;
                            r_wday  <= '0;
                            r_state <= S_DONE;
                        end else begin
                            r_err   <= 1'b0;
                            r_acc   <= AW'(adj[EPOCH_BITS-1:0]);
                            r_dvs   <= AW'(e2cal_pkg::SECS_PER_DAY) << (DQ - 1);
                            r_cnt   <= CNTW'(DQ - 1);
                            r_state <= S_DAYS;
                        end
                    end
                end
                S_DAYS: begin
                    if (ge) begin
                        r_acc <= diff;
                    end
                    r_days <= {r_days[DQ-2:0], ge};
                    r_dvs  <= r_dvs >> 1;
                    r_cnt  <= r_cnt - CNTW'(1);
                    if (cnt_end) begin
                        r_dvs   <= AW'(e2cal_pkg::SECS_PER_HOUR) << (e2cal_pkg::HOUR_STEPS - 1);
                        r_cnt   <= CNTW'(e2cal_pkg::HOUR_STEPS - 1);
                        r_state <= S_HOUR;
                    end
                end
                S_HOUR: begin
                    if (ge) begin
                        r_acc <= diff;
                    end
                    r_hour <= {r_hour[3:0], ge};
                    r_dvs  <= r_dvs >> 1;
                    r_cnt  <= r_cnt - CNTW'(1);
                    if (cnt_end) begin
                        r_dvs   <= AW'(e2cal_pkg::SECS_PER_MIN) << (e2cal_pkg::MIN_STEPS - 1);
                        r_cnt   <= CNTW'(e2cal_pkg::MIN_STEPS - 1);
                        r_state <= S_MIN;
                    end
                end
                S_MIN: begin
                    r_min <= {r_min[4:0], ge};
                    r_dvs <= r_dvs >> 1;
                    r_cnt <= r_cnt - CNTW'(1);
                    if (ge) begin
                        r_acc <= diff;
                    end
                    if (cnt_end) begin
                        r_sec   <= ge ? diff[5:0] : r_acc[5:0];
                        r_acc   <= AW'(r_days);
                        r_wday  <= 3'(e2cal_pkg::WEEKDAY_BASE);
                        r_state <= S_YEAR;
                    end
                end
                S_YEAR: begin
                    if (ge) begin
                        r_acc  <= diff;
                        r_wday <= e2cal_pkg::wday_add(r_wday, yinfo.leap ? 2'd2 : 2'd1);
                    end else begin
                        r_yday  <= r_acc[8:0];
                        r_month <= e2cal_pkg::MON_JAN;
                        r_state <= S_MONTH;
                    end
                end
                S_MONTH: begin
                    if ((r_month != e2cal_pkg::MON_DEC) && ge) begin
                        r_acc   <= diff;
                        r_month <= r_month + 4'd1;
                        r_wday  <= e2cal_pkg::wday_add(r_wday,
                                       2'(mlen - 5'(e2cal_pkg::FEB_DAYS)));
                    end else begin
                        r_dom   <= r_acc[4:0] + 5'd1;
                        r_wday  <= e2cal_pkg::wday_mod(6'(r_wday) + 6'(r_acc[4:0]));
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (o_cal.ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_epoch.ready      = (r_state == S_IDLE);
    assign o_cal.valid        = (r_state == S_DONE);
    assign o_cal.year         = r_err ? '0 : yinfo.year;
    assign o_cal.month        = r_month;
    assign o_cal.day_of_month = r_dom;
    assign o_cal.day_of_year  = r_yday;
    assign o_cal.hour         = r_hour;
    assign o_cal.minute       = r_min;
    assign o_cal.second       = r_sec;
    assign o_cal.weekday      = r_wday;
    assign o_cal.range_error  = r_err;

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cal.valid && i_epoch.ready))
        else $error("result held while input is open");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !i_epoch.ready)
        else $error("input open right after an accepted item");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cal.valid && o_cal.range_error) |->
            (o_cal.year == '0 && o_cal.month == '0 && o_cal.day_of_month == '0 &&
             o_cal.hour == '0 && o_cal.weekday == '0))
        else $error("error result carries non-zero fields");

    a_fields_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cal.valid && !o_cal.range_error) |->
            (o_cal.month <= e2cal_pkg::MON_DEC && o_cal.day_of_month != '0 &&
             o_cal.hour <= 5'd23 && o_cal.minute <= 6'd59 && o_cal.second <= 6'd59 &&
             o_cal.weekday <= 3'd6))
        else $error("result field out of range");

    a_month_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MONTH) |-> (r_month <= e2cal_pkg::MON_DEC))
        else $error("month walk passed December");

endmodule
